// ===== hw/rtl/qelt_pkg.sv =====
// qelt_pkg: types, codes and the per-byte line logic of the tokenizer
// used by quoted_escaped_line_tokenizer; no dependencies

package qelt_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 64;
    localparam int unsigned ResDepth = 3;
    localparam int unsigned CntW     = 2;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [63:0] DELIM_LOW_RST = 64'd4294977024;
    localparam logic [7:0]  QUOTE_RST     = 8'h22;
    localparam logic [7:0]  ESCAPE_RST    = 8'h5C;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DELIM_LOW      = 3'd0,
        REG_DELIM_MID_LOW  = 3'd1,
        REG_DELIM_MID_HIGH = 3'd2,
        REG_DELIM_HIGH     = 3'd3,
        REG_QUOTE_BYTE     = 3'd4,
        REG_ESCAPE_BYTE    = 3'd5,
        REG_KEEP_EMPTY     = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_LINE_END  = 2'd2
    } kind_t;

    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic in_quote;
        logic escape_pending;
        logic token_nonempty;
        logic line_nonempty;
        logic cr_held;
    } tok_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] token_byte;
        logic       last;
    } result_t;

    typedef struct packed {
        tok_state_t st;
        logic       emit;
        kind_t      kind;
        logic [7:0] token_byte;
    } line_step_t;

    // one in-line byte: escape first, then quote, then delimiter map
    function automatic line_step_t line_byte(
        input tok_state_t st,
        input logic [7:0] c,
        input logic       is_delim,
        input logic [7:0] quote_byte,
        input logic [7:0] escape_byte,
        input logic       keep_empty
    );
        line_step_t r;
        r.st         = st;
        r.emit       = 1'b0;
        r.kind       = KIND_BYTE;
        r.token_byte = 8'h00;
        if (st.escape_pending) begin
            r.st.escape_pending = 1'b0;
            r.st.token_nonempty = 1'b1;
            r.emit              = 1'b1;
            r.token_byte        = c;
        end else if (c == escape_byte) begin
            r.st.escape_pending = 1'b1;
        end else if (c == quote_byte) begin
            r.st.in_quote = ~st.in_quote;
        end else if (!st.in_quote && is_delim) begin
            r.emit              = keep_empty | st.token_nonempty;
            r.kind              = KIND_TOKEN_END;
            r.st.token_nonempty = 1'b0;
        end else begin
            r.st.token_nonempty = 1'b1;
            r.emit              = 1'b1;
            r.token_byte        = c;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/quoted_escaped_line_tokenizer.sv =====
// quoted_escaped_line_tokenizer: splits a byte stream into lines and tokens
// with quoting, escaping and a configurable delimiter map; depends on qelt_pkg
//
//  channel | direction | ports                                  | transfer when
//  s_      | in        | s_mode, s_byte_in                      | s_valid & s_ready
//  m_      | out       | m_kind, m_token_byte, m_last           | m_valid & m_ready
//  cfg_    | in        | cfg_index, cfg_data                    | cfg_valid & cfg_ready
//
// one input transfer per cycle while each item gives at most one result and the
// receiver takes each result; an item giving two or three results holds s_ready
// low while its results drain from the three-entry result register
// a result register parts the sides: the next item is taken in the cycle its
// predecessor's last result leaves; aresetn is synchronous and clears the
// scan state, result count and configuration to their defaults

module quoted_escaped_line_tokenizer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [7:0]                   s_byte_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_kind,
    output logic [7:0]                   m_token_byte,
    output logic                         m_last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [qelt_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [qelt_pkg::CfgDataW-1:0] cfg_data
);
    import qelt_pkg::*;

    logic [63:0] delim_low_reg, delim_mid_low_reg, delim_mid_high_reg, delim_high_reg;
    logic [7:0]  quote_reg, escape_reg;
    logic        keep_empty_reg;

    tok_state_t  st_reg, st_next;
    result_t     res_reg [ResDepth];
    result_t     res_next [ResDepth];
    logic [CntW-1:0] cnt_reg, cnt_next;

    logic        s_xfer, m_xfer, cfg_xfer;
    logic [63:0] map_sel;
    logic        c_is_delim, cr_is_delim;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid & cfg_ready;
    assign m_valid   = (cnt_reg != '0);
    assign m_xfer    = m_valid & m_ready;
    assign s_ready   = (cnt_reg == '0) || ((cnt_reg == CntW'(1)) && m_ready);
    assign s_xfer    = s_valid & s_ready;

    assign m_kind       = res_reg[0].kind;
    assign m_token_byte = res_reg[0].token_byte;
    assign m_last       = res_reg[0].last;

    always_comb begin
        case (s_byte_in[7:6])
            2'd0:    map_sel = delim_low_reg;
            2'd1:    map_sel = delim_mid_low_reg;
            2'd2:    map_sel = delim_mid_high_reg;
            default: map_sel = delim_high_reg;
        endcase
    end
    assign c_is_delim  = map_sel[s_byte_in[5:0]];
    assign cr_is_delim = delim_low_reg[CH_CR[5:0]];

    // whole item in one pass: held CR, then the new byte or the line end
    always_comb begin
        tok_state_t      st;
        line_step_t      lb;
        result_t         res [ResDepth];
        logic [CntW-1:0] n;
        logic            do_cr, do_byte, do_end;

        st      = st_reg;
        lb      = '0;
        n       = '0;
        do_cr   = 1'b0;
        do_byte = 1'b0;
        do_end  = 1'b0;
        for (int i = 0; i < ResDepth; i++) begin
            res[i] = '{kind: KIND_BYTE, token_byte: 8'h00, last: 1'b0};
        end

        if (s_mode == MODE_FLUSH) begin
            do_cr  = st_reg.line_nonempty & st_reg.cr_held;
            do_end = st_reg.line_nonempty;
        end else if (s_byte_in == CH_LF) begin
            do_end = 1'b1;
        end else begin
            st.line_nonempty = 1'b1;
            do_cr            = st_reg.cr_held;
            do_byte          = (s_byte_in != CH_CR);
        end

        if (do_cr) begin
            lb = line_byte(st, CH_CR, cr_is_delim, quote_reg, escape_reg, keep_empty_reg);
            st = lb.st;
            if (lb.emit) begin
                res[n] = '{kind: lb.kind, token_byte: lb.token_byte, last: 1'b0};
                n      = n + CntW'(1);
            end
        end
        if (s_mode == MODE_DATA && s_byte_in != CH_LF) begin
            st.cr_held = (s_byte_in == CH_CR);
        end
        if (do_byte) begin
            lb = line_byte(st, s_byte_in, c_is_delim, quote_reg, escape_reg,
                           keep_empty_reg);
            st = lb.st;
            if (lb.emit) begin
                res[n] = '{kind: lb.kind, token_byte: lb.token_byte, last: 1'b0};
                n      = n + CntW'(1);
            end
        end
        if (do_end) begin
            if (keep_empty_reg || st.token_nonempty) begin
                res[n] = '{kind: KIND_TOKEN_END, token_byte: 8'h00, last: 1'b0};
                n      = n + CntW'(1);
            end
            res[n] = '{kind: KIND_LINE_END, token_byte: 8'h00, last: 1'b0};
            n      = n + CntW'(1);
            st     = '0;
        end
        if (n != '0) begin
            res[n - CntW'(1)].last = 1'b1;
        end

        // default: drain by shifting toward slot 0
        st_next  = st_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        if (m_xfer) begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            cnt_next    = cnt_reg - CntW'(1);
        end
        if (s_xfer) begin
            st_next  = st;
            res_next = res;
            cnt_next = n;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (!aresetn) begin
            st_reg             <= '0;
            cnt_reg            <= '0;
            delim_low_reg      <= DELIM_LOW_RST;
            delim_mid_low_reg  <= '0;
            delim_mid_high_reg <= '0;
            delim_high_reg     <= '0;
            quote_reg          <= QUOTE_RST;
            escape_reg         <= ESCAPE_RST;
            keep_empty_reg     <= 1'b0;
        end else begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            if (cfg_xfer) begin
                case (cfg_index)
                    REG_DELIM_LOW:      delim_low_reg      <= cfg_data;
                    REG_DELIM_MID_LOW:  delim_mid_low_reg  <= cfg_data;
                    REG_DELIM_MID_HIGH: delim_mid_high_reg <= cfg_data;
                    REG_DELIM_HIGH:     delim_high_reg     <= cfg_data;
                    REG_QUOTE_BYTE:     quote_reg          <= cfg_data[7:0];
                    REG_ESCAPE_BYTE:    escape_reg         <= cfg_data[7:0];
                    REG_KEEP_EMPTY:     keep_empty_reg     <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // the final result of an item is always the last one held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (cnt_reg == CntW'(1)))
        else $error("last flag on a result that is not the final one held");

    // a line end always closes its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_LINE_END) |-> m_last)
        else $error("line end result without last flag");

    // a flush on an empty line gives nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_mode == MODE_FLUSH && !st_reg.line_nonempty) |=> !m_valid)
        else $error("flush on empty line produced a result");

endmodule

// ===== test/tb_quoted_escaped_line_tokenizer.sv =====
// tb_quoted_escaped_line_tokenizer: self-checking testbench for the line and token splitter
// scores every result transfer against a behavioral tokenizer kept in step with the block
// depends on qelt_pkg and quoted_escaped_line_tokenizer

module tb_quoted_escaped_line_tokenizer;
    import qelt_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLDOFF_CYCLES = 64;
    localparam int STREAM_ITEMS   = 48;

    // index past the last register, writes to it must change nothing
    localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_mode;
    logic [7:0]          s_byte_in;
    logic                m_valid;
    logic                m_ready;
    logic [1:0]          m_kind;
    logic [7:0]          m_token_byte;
    logic                m_last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    // tokenizer state and register copy
    logic [63:0] delim_bits [4];
    logic [7:0]  quote_code;
    logic [7:0]  escape_code;
    logic        keep_empty_tokens;
    logic        quoted;
    logic        escape_armed;
    logic        token_has_bytes;
    logic        line_has_bytes;
    logic        cr_waiting;

    result_t expected_tokens [$];
    int      mismatch_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      holdoffs_requested;
    int      holdoffs_served;

    quoted_escaped_line_tokenizer i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_byte_in    (s_byte_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_token_byte (m_token_byte),
        .m_last       (m_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic void add_result(kind_t k, logic [7:0] b);
        result_t r;
        r.kind       = k;
        r.token_byte = b;
        r.last       = 1'b0;
        expected_tokens.push_back(r);
    endfunction

    function automatic void scan_line_byte(logic [7:0] c);
        if (escape_armed) begin
            escape_armed    = 1'b0;
            token_has_bytes = 1'b1;
            add_result(KIND_BYTE, c);
        end else if (c == escape_code) begin
            escape_armed = 1'b1;
        end else if (c == quote_code) begin
            quoted = ~quoted;
        end else if (!quoted && delim_bits[c[7:6]][c[5:0]]) begin
            if (keep_empty_tokens || token_has_bytes) begin
                add_result(KIND_TOKEN_END, 8'h00);
            end
            token_has_bytes = 1'b0;
        end else begin
            token_has_bytes = 1'b1;
            add_result(KIND_BYTE, c);
        end
    endfunction

    function automatic void close_line();
        if (keep_empty_tokens || token_has_bytes) begin
            add_result(KIND_TOKEN_END, 8'h00);
        end
        add_result(KIND_LINE_END, 8'h00);
        quoted          = 1'b0;
        escape_armed    = 1'b0;
        token_has_bytes = 1'b0;
        line_has_bytes  = 1'b0;
        cr_waiting      = 1'b0;
    endfunction

    function automatic void tokenize_item(logic mode, logic [7:0] c);
        int      n_prior;
        result_t tail;
        n_prior = expected_tokens.size();
        if (mode == MODE_FLUSH) begin
            if (line_has_bytes) begin
                if (cr_waiting) begin
                    cr_waiting = 1'b0;
                    scan_line_byte(CH_CR);
                end
                close_line();
            end
        end else if (c == CH_LF) begin
            cr_waiting = 1'b0;
            close_line();
        end else begin
            line_has_bytes = 1'b1;
            if (cr_waiting) begin
                cr_waiting = 1'b0;
                scan_line_byte(CH_CR);
            end
            if (c == CH_CR) begin
                cr_waiting = 1'b1;
            end else begin
                scan_line_byte(c);
            end
        end
        if (expected_tokens.size() > n_prior) begin
            tail      = expected_tokens.pop_back();
            tail.last = 1'b1;
            expected_tokens.push_back(tail);
        end
    endfunction

    function automatic void mirror_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        case (idx)
            REG_DELIM_LOW, REG_DELIM_MID_LOW, REG_DELIM_MID_HIGH, REG_DELIM_HIGH:
                delim_bits[idx[1:0]] = data;
            REG_QUOTE_BYTE:  quote_code = data[7:0];
            REG_ESCAPE_BYTE: escape_code = data[7:0];
            REG_KEEP_EMPTY:  keep_empty_tokens = data[0];
            default: ;
        endcase
    endfunction

    // predict on input transfers, score output transfers
    always @(posedge aclk) begin : track_transfers
        result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                mirror_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                tokenize_item(s_mode, s_byte_in);
            end
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected result: kind %0d byte 0x%02h last %0d",
                           m_kind, m_token_byte, m_last);
                    mismatch_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_kind);
                        mismatch_count++;
                    end
                    if (m_token_byte !== want.token_byte) begin
                        $error("token_byte: expected 0x%02h, got 0x%02h",
                               want.token_byte, m_token_byte);
                        mismatch_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial begin : result_sink
        int held;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (holdoffs_served != holdoffs_requested) begin
                m_ready <= 1'b0;
                held = 1;
                while (held < HOLDOFF_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
                holdoffs_served++;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic mode, input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_byte_in <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_items(input logic [8:0] items [$]);
        foreach (items[i]) begin
            send_item(items[i][8], items[i][7:0]);
        end
    endtask

    // text-like mix so quoting, escaping and line ends come up often
    task automatic send_random_item();
        int         pick;
        logic [7:0] b;
        logic       mode;
        pick = $urandom_range(99);
        b    = 8'($urandom_range(255));
        mode = MODE_DATA;
        if (pick < 35) begin
            b = 8'h61 + 8'($urandom_range(25));
        end else if (pick < 48) begin
            b = $urandom_range(1) ? 8'h20 : 8'h09;
        end else if (pick < 56) begin
            b = quote_code;
        end else if (pick < 63) begin
            b = escape_code;
        end else if (pick < 70) begin
            b = CH_CR;
        end else if (pick < 78) begin
            b = CH_LF;
        end else if (pick < 83) begin
            mode = MODE_FLUSH;
        end
        send_item(mode, b);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_tokens.size() != 0) @(posedge aclk);
        // an item with no result may still be inside the block
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // narrow registers get junk above their width, which must be ignored
    task automatic load_config(input logic [63:0] m0, input logic [63:0] m1,
                               input logic [63:0] m2, input logic [63:0] m3,
                               input logic [7:0] q, input logic [7:0] e, input logic keep);
        write_reg(REG_DELIM_LOW, m0);
        write_reg(REG_SPARE, {$urandom, $urandom});
        write_reg(REG_DELIM_MID_LOW, m1);
        write_reg(REG_DELIM_MID_HIGH, m2);
        write_reg(REG_DELIM_HIGH, m3);
        write_reg(REG_QUOTE_BYTE, {$urandom, 24'($urandom), q});
        write_reg(REG_ESCAPE_BYTE, {$urandom, 24'($urandom), e});
        write_reg(REG_KEEP_EMPTY, {$urandom, 31'($urandom), keep});
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random_config();
        logic [63:0] low_map;
        logic [7:0]  q;
        logic [7:0]  e;
        low_map = $urandom_range(1) ? DELIM_LOW_RST : {$urandom, $urandom};
        q       = $urandom_range(1) ? QUOTE_RST : 8'($urandom_range(255));
        e       = $urandom_range(1) ? ESCAPE_RST : 8'($urandom_range(255));
        load_config(low_map,
                    {$urandom, $urandom} & {$urandom, $urandom},
                    {$urandom, $urandom} & {$urandom, $urandom},
                    {$urandom, $urandom},
                    q, e, 1'($urandom_range(1)));
    endtask

    // reset settings: quoting, escapes, held and dropped CR, flushes
    task automatic test_default_scan();
        logic [8:0] items [$];
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        items = '{{MODE_DATA, 8'h61}, {MODE_DATA, 8'h20}, {MODE_DATA, 8'h20},
                  {MODE_DATA, 8'h22}, {MODE_DATA, 8'h20}, {MODE_DATA, 8'h22},
                  {MODE_DATA, 8'h5C}, {MODE_DATA, 8'h22}, {MODE_DATA, 8'h0D},
                  {MODE_DATA, 8'h62}, {MODE_DATA, 8'h0D}, {MODE_DATA, 8'h0A},
                  {MODE_FLUSH, 8'hA5}, {MODE_DATA, 8'h22}, {MODE_DATA, 8'h5C},
                  {MODE_DATA, 8'h0A}, {MODE_DATA, 8'h0D}, {MODE_FLUSH, 8'h5A}};
        send_items(items);
    endtask

    // full and empty maps, extreme codes, codes that overlap CR and LF
    task automatic test_register_extremes();
        logic [8:0] items [$];
        wait_drain();
        load_config('1, '1, '1, '1, 8'h00, 8'hFF, 1'b1);
        items = '{{MODE_DATA, 8'h00}, {MODE_DATA, 8'h20}, {MODE_DATA, 8'h00},
                  {MODE_DATA, 8'h20}, {MODE_DATA, 8'hFF}, {MODE_DATA, 8'hFF},
                  {MODE_DATA, 8'h0A}};
        send_items(items);
        wait_drain();
        load_config(DELIM_LOW_RST, '0, '0, '0, CH_LF, CH_CR, 1'b0);
        items = '{{MODE_DATA, 8'h0D}, {MODE_DATA, 8'h61}, {MODE_DATA, 8'h0D},
                  {MODE_DATA, 8'h0A}};
        send_items(items);
    endtask

    task automatic test_random_stream(input int sender_idle, input int receiver_stall);
        wait_drain();
        load_random_config();
        send_idle_pct  = sender_idle;
        recv_stall_pct = receiver_stall;
        repeat (STREAM_ITEMS) send_random_item();
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_result_backpressure();
        wait_drain();
        load_config(DELIM_LOW_RST, '0, '0, '0, QUOTE_RST, ESCAPE_RST, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 12;
        holdoffs_requested++;
        repeat (40) send_random_item();
    endtask

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_mode             = MODE_DATA;
        s_byte_in          = 8'h00;
        cfg_valid          = 1'b0;
        cfg_index          = REG_DELIM_LOW;
        cfg_data           = '0;
        mismatch_count     = 0;
        cycle_count        = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        holdoffs_requested = 0;
        holdoffs_served    = 0;
        delim_bits[0]      = DELIM_LOW_RST;
        delim_bits[1]      = '0;
        delim_bits[2]      = '0;
        delim_bits[3]      = '0;
        quote_code         = QUOTE_RST;
        escape_code        = ESCAPE_RST;
        keep_empty_tokens  = 1'b0;
        quoted             = 1'b0;
        escape_armed       = 1'b0;
        token_has_bytes    = 1'b0;
        line_has_bytes     = 1'b0;
        cr_waiting         = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_scan();
        test_register_extremes();
        test_random_stream(0, 0);
        test_random_stream(79, 0);
        test_random_stream(0, 79);
        test_random_stream(12, 12);
        test_result_backpressure();
        wait_drain();

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
